// ===== hw/rtl/ft12_pkg.sv =====
package ft12_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned AsizeW  = 2;
  localparam int unsigned FuncW   = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_SIZE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATION_ADDRESS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REQUEST_FUNCTION = 2'd2;

  localparam logic [AsizeW-1:0] ASIZE_RESET = 2'd1;

  // Input operations
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Link characters
  localparam logic [ByteW-1:0] CHR_ACK      = 8'hE5;
  localparam logic [ByteW-1:0] CHR_FIXED    = 8'h10;
  localparam logic [ByteW-1:0] CHR_VARIABLE = 8'h68;
  localparam logic [ByteW-1:0] CHR_END      = 8'h16;

  // Request functions that make an ack read as function 9
  localparam logic [FuncW-1:0] FUNC_REQ_CLASS1 = 4'hA;
  localparam logic [FuncW-1:0] FUNC_REQ_CLASS2 = 4'hB;
  localparam logic [FuncW-1:0] FUNC_ACK_NACK   = 4'h9;
  localparam logic [FuncW-1:0] FUNC_NONE       = 4'h0;

  // Result kinds
  localparam logic [KindW-1:0] KIND_DATA     = 2'd0;
  localparam logic [KindW-1:0] KIND_ACK      = 2'd1;
  localparam logic [KindW-1:0] KIND_FIXED    = 2'd2;
  localparam logic [KindW-1:0] KIND_VARIABLE = 2'd3;

  // Frame status
  localparam logic [StatusW-1:0] ST_GOOD     = 2'd0;
  localparam logic [StatusW-1:0] ST_CHECKSUM = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_END   = 2'd2;
  localparam logic [StatusW-1:0] ST_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic [AsizeW-1:0] address_size;
    logic [AddrW-1:0]  station_address;
    logic [FuncW-1:0]  request_function;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]   result_kind;
    logic [ByteW-1:0]   data_byte;
    logic [StatusW-1:0] status;
    logic [FuncW-1:0]   function_code;
    logic               access_demand;
    logic               flow_control;
    logic               direction_bit;
    logic               primary_bit;
    logic               address_match;
    logic [ByteW-1:0]   user_length;
  } result_t;

endpackage

// ===== hw/rtl/ft12_frame_receiver_top.sv =====
// FT1.2 link-frame receiver: decodes single-char acks, fixed and variable frames.
// Input channel: in_valid_i / in_stall_o carry one item per accept: operation_i
//   (0 received octet, 1 receive timeout) and byte_value_i.
// Output channel: out_valid_o / out_stall_i carry at most one result item per
//   input item: a user-data byte, an ack, or a frame end with status, control
//   bits, address match and user length.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_index_i (0 address
//   size, 1 station address, 2 request function); write only while idle.
// Path: an accepted item is held in the input register and decoded from there
//   when it is taken; its result is loaded into the result register, from
//   which out_valid_o / out_stall_i hand it on.
// Throughput: one item per cycle while out_stall_i is low; the input register
//   and the result register decouple the two sides, and the decode is a single
//   pass over the frame state held in flops.
// Stall: while out_stall_i holds a full result register, the next item waits
//   in the input register and in_stall_o rises once that is full too.
// Reset: hunting for a start character, no items in flight, config at
//   address size 1, station address 0, request function 0.
module ft12_frame_receiver_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ft12_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ft12_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [ft12_pkg::ByteW-1:0]        byte_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ft12_pkg::KindW-1:0]        result_kind_o,
  output logic [ft12_pkg::ByteW-1:0]        data_byte_o,
  output logic [ft12_pkg::StatusW-1:0]      status_o,
  output logic [ft12_pkg::FuncW-1:0]        function_code_o,
  output logic                              access_demand_o,
  output logic                              flow_control_o,
  output logic                              direction_bit_o,
  output logic                              primary_bit_o,
  output logic                              address_match_o,
  output logic [ft12_pkg::ByteW-1:0]        user_length_o
);

  ft12_pkg::cfg_t             cfg_q;
  logic                       in_valid_q;
  logic                       op_q;
  logic [ft12_pkg::ByteW-1:0] byte_q;
  logic                       accept;
  logic                       take;
  logic                       res_valid;
  ft12_pkg::result_t          res;
  ft12_pkg::result_t          out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_size     <= ft12_pkg::ASIZE_RESET;
      cfg_q.station_address  <= '0;
      cfg_q.request_function <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ft12_pkg::CFG_ADDRESS_SIZE:
          cfg_q.address_size <= cfg_wdata_i[ft12_pkg::AsizeW-1:0];
        ft12_pkg::CFG_STATION_ADDRESS:
          cfg_q.station_address <= cfg_wdata_i[ft12_pkg::AddrW-1:0];
        ft12_pkg::CFG_REQUEST_FUNCTION:
          cfg_q.request_function <= cfg_wdata_i[ft12_pkg::FuncW-1:0];
        default: ;
      endcase
    end
  end

  // decode advances when the result slot is free or draining
  assign take       = in_valid_q & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~take;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept | (in_valid_q & ~take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      byte_q <= byte_value_i;
    end
  end

  ft12_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .operation_i  (op_q),
    .byte_value_i (byte_q),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ft12_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take & res_valid),
    .res_i   (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign result_kind_o   = out_res.result_kind;
  assign data_byte_o     = out_res.data_byte;
  assign status_o        = out_res.status;
  assign function_code_o = out_res.function_code;
  assign access_demand_o = out_res.access_demand;
  assign flow_control_o  = out_res.flow_control;
  assign direction_bit_o = out_res.direction_bit;
  assign primary_bit_o   = out_res.primary_bit;
  assign address_match_o = out_res.address_match;
  assign user_length_o   = out_res.user_length;

endmodule

// ===== hw/rtl/ft12_decoder.sv =====
module ft12_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic                           operation_i,
  input  logic [ft12_pkg::ByteW-1:0]     byte_value_i,
  input  ft12_pkg::cfg_t                 cfg_i,
  output logic                           res_valid_o,
  output ft12_pkg::result_t              res_o
);

  localparam logic [3:0] PH_HUNT     = 4'd0;
  localparam logic [3:0] PH_VLEN1    = 4'd1;
  localparam logic [3:0] PH_VLEN2    = 4'd2;
  localparam logic [3:0] PH_VSTART   = 4'd3;
  localparam logic [3:0] PH_VBODY    = 4'd4;
  localparam logic [3:0] PH_VCHK     = 4'd5;
  localparam logic [3:0] PH_VEND_OK  = 4'd6;
  localparam logic [3:0] PH_VEND_BAD = 4'd7;
  localparam logic [3:0] PH_FBODY    = 4'd8;
  localparam logic [3:0] PH_FCHK     = 4'd9;
  localparam logic [3:0] PH_FEND_OK  = 4'd10;
  localparam logic [3:0] PH_FEND_BAD = 4'd11;

  logic [3:0]                   phase_q, phase_d;
  logic [ft12_pkg::ByteW-1:0]   index_q, index_d;
  logic [ft12_pkg::ByteW-1:0]   length_q, length_d;
  logic [ft12_pkg::ByteW-1:0]   sum_q, sum_d;
  logic [ft12_pkg::ByteW-1:0]   control_q, control_d;
  logic [ft12_pkg::AddrW-1:0]   address_q, address_d;

  logic                         two_octets;
  logic [ft12_pkg::ByteW-1:0]   hdr_len;     // control plus address octets
  logic [ft12_pkg::ByteW-1:0]   index_inc;
  logic                         addr_match;
  logic [ft12_pkg::StatusW-1:0] end_status;
  logic                         end_bad;
  logic [ft12_pkg::ByteW-1:0]   user_len;
  logic                         in_frame;

  assign two_octets = (cfg_i.address_size >= 2'd2);
  assign hdr_len    = two_octets ? 8'd3 : 8'd2;
  assign index_inc  = index_q + 8'd1;
  assign addr_match = (address_q == cfg_i.station_address);
  assign end_bad    = (phase_q == PH_VEND_BAD) || (phase_q == PH_FEND_BAD);
  assign end_status = (byte_value_i != ft12_pkg::CHR_END) ? ft12_pkg::ST_NO_END :
                      (end_bad ? ft12_pkg::ST_CHECKSUM : ft12_pkg::ST_GOOD);
  assign user_len   = (length_q > hdr_len) ? (length_q - hdr_len) : 8'd0;
  assign in_frame   = (phase_q != PH_HUNT) && (phase_q <= PH_FEND_BAD);

  always_comb begin
    phase_d     = phase_q;
    index_d     = index_q;
    length_d    = length_q;
    sum_d       = sum_q;
    control_d   = control_q;
    address_d   = address_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // frame-end fields, overridden where they do not apply
    res_o.function_code = control_q[3:0];
    res_o.access_demand = control_q[5];
    res_o.flow_control  = control_q[4];
    res_o.direction_bit = control_q[7];
    res_o.primary_bit   = control_q[6];

    if (operation_i == ft12_pkg::OP_TIMEOUT) begin
      phase_d = PH_HUNT;
      if (in_frame) begin
        res_valid_o       = 1'b1;
        res_o.result_kind = (phase_q >= PH_FBODY) ? ft12_pkg::KIND_FIXED
                                                  : ft12_pkg::KIND_VARIABLE;
        res_o.status      = ft12_pkg::ST_TIMEOUT;
      end
    end else begin
      unique case (phase_q)
        PH_VLEN1: begin
          length_d = byte_value_i;
          phase_d  = PH_VLEN2;
        end
        PH_VLEN2: begin
          phase_d = (byte_value_i == length_q) ? PH_VSTART : PH_HUNT;
        end
        PH_VSTART: begin
          if (byte_value_i != ft12_pkg::CHR_VARIABLE || length_q < hdr_len) begin
            phase_d = PH_HUNT;
          end else begin
            index_d   = '0;
            sum_d     = '0;
            control_d = '0;
            address_d = '0;
            phase_d   = PH_VBODY;
          end
        end
        PH_VBODY, PH_FBODY: begin
          sum_d   = sum_q + byte_value_i;
          index_d = index_inc;
          if (index_q == 8'd0) begin
            control_d = byte_value_i;
          end else if (index_q == 8'd1) begin
            address_d[7:0] = byte_value_i;
          end else if (index_q == 8'd2 && two_octets) begin
            address_d[15:8] = byte_value_i;
          end
          if (phase_q == PH_VBODY) begin
            if (index_inc >= length_q) begin
              phase_d = PH_VCHK;
            end
            if (index_q >= hdr_len) begin
              res_valid_o   = 1'b1;
              res_o         = '0;
              res_o.result_kind = ft12_pkg::KIND_DATA;
              res_o.data_byte   = byte_value_i;
            end
          end else if (index_inc >= hdr_len) begin
            phase_d = PH_FCHK;
          end
        end
        PH_VCHK: begin
          phase_d = (byte_value_i == sum_q) ? PH_VEND_OK : PH_VEND_BAD;
        end
        PH_FCHK: begin
          phase_d = (byte_value_i == sum_q) ? PH_FEND_OK : PH_FEND_BAD;
        end
        PH_VEND_OK, PH_VEND_BAD, PH_FEND_OK, PH_FEND_BAD: begin
          phase_d             = PH_HUNT;
          res_valid_o         = 1'b1;
          res_o.status        = end_status;
          res_o.address_match = addr_match;
          if (phase_q <= PH_VEND_BAD) begin
            res_o.result_kind = ft12_pkg::KIND_VARIABLE;
            res_o.user_length = user_len;
          end else begin
            res_o.result_kind = ft12_pkg::KIND_FIXED;
          end
        end
        default: begin
          // hunting (and unused codes)
          phase_d = PH_HUNT;
          if (byte_value_i == ft12_pkg::CHR_ACK) begin
            res_valid_o       = 1'b1;
            res_o             = '0;
            res_o.result_kind = ft12_pkg::KIND_ACK;
            res_o.function_code =
                (cfg_i.request_function == ft12_pkg::FUNC_REQ_CLASS1 ||
                 cfg_i.request_function == ft12_pkg::FUNC_REQ_CLASS2)
                ? ft12_pkg::FUNC_ACK_NACK : ft12_pkg::FUNC_NONE;
          end else if (byte_value_i == ft12_pkg::CHR_FIXED) begin
            index_d   = '0;
            sum_d     = '0;
            control_d = '0;
            address_d = '0;
            phase_d   = PH_FBODY;
          end else if (byte_value_i == ft12_pkg::CHR_VARIABLE) begin
            phase_d = PH_VLEN1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      index_q   <= '0;
      length_q  <= '0;
      sum_q     <= '0;
      control_q <= '0;
      address_q <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      index_q   <= index_d;
      length_q  <= length_d;
      sum_q     <= sum_d;
      control_q <= control_d;
      address_q <= address_d;
    end
  end

  // a timeout taken while hunting never yields an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT && operation_i == ft12_pkg::OP_TIMEOUT) |-> !res_valid_o)
    else $error("result from a timeout while hunting");

  // a frame end always sends the decoder back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && res_valid_o &&
     (res_o.result_kind == ft12_pkg::KIND_FIXED ||
      res_o.result_kind == ft12_pkg::KIND_VARIABLE)) |=> (phase_q == PH_HUNT))
    else $error("frame end did not return to hunting");

  // user data only comes out of the variable-frame body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.result_kind == ft12_pkg::KIND_DATA) |->
      (phase_q == PH_VBODY && res_o.status == ft12_pkg::ST_GOOD))
    else $error("data item outside a variable frame body");

  // the body index never runs past the declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VBODY) |-> (index_q < length_q))
    else $error("body index past frame length");

endmodule

// ===== hw/rtl/ft12_out_reg.sv =====
module ft12_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ft12_pkg::result_t res_i,
  input  logic              stall_i,
  output logic              valid_o,
  output ft12_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  ft12_pkg::result_t res_q;

  // load_i only arrives when the slot is empty or draining this cycle
  assign valid_d = load_i | (valid_q & stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ft12_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT, S_VAR_LEN, S_VAR_LEN_COPY, S_VAR_START2, S_VAR_BODY, S_VAR_SUM,
    S_VAR_END_GOOD, S_VAR_END_BADSUM, S_FIX_BODY, S_FIX_SUM, S_FIX_END_GOOD,
    S_FIX_END_BADSUM
  } rx_state_e;

  typedef enum int {
    FLT_NONE, FLT_SUM, FLT_END, FLT_BOTH, FLT_CUT, FLT_LEN_DIFF, FLT_NO_START2,
    FLT_SHORT_LEN
  } frame_fault_e;

  class frame_scoreboard;
    logic [AsizeW-1:0] asize;
    logic [AddrW-1:0]  station;
    logic [FuncW-1:0]  req_func;
    rx_state_e         fsm;
    logic [7:0]        pos;
    logic [7:0]        len_field;
    logic [7:0]        csum;
    logic [7:0]        ctrl_byte;
    logic [15:0]       link_addr;
    result_t           due[$];
    int unsigned       mismatches;

    function new();
      asize = ASIZE_RESET;
      station = '0;
      req_func = '0;
      fsm = S_HUNT;
      pos = '0;
      len_field = '0;
      csum = '0;
      ctrl_byte = '0;
      link_addr = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
      case (index)
        CFG_ADDRESS_SIZE:     asize = value[AsizeW-1:0];
        CFG_STATION_ADDRESS:  station = value;
        CFG_REQUEST_FUNCTION: req_func = value[FuncW-1:0];
        default: ;
      endcase
    endfunction

    // address field width in octets; 0 reads as 1, 3 as 2
    function int unsigned octets();
      return (asize >= 2) ? 2 : 1;
    endfunction

    function void clear_body();
      pos = '0;
      csum = '0;
      ctrl_byte = '0;
      link_addr = '0;
    endfunction

    // control/address/data octet of a frame body; returns 1 for user data
    function bit absorb_body(logic [7:0] b);
      int unsigned n;
      n = octets();
      csum += b;
      if (pos == 0) ctrl_byte = b;
      else if (pos == 1) link_addr[7:0] = b;
      else if (pos == 2 && n == 2) link_addr[15:8] = b;
      return pos > n;
    endfunction

    function result_t frame_summary(logic [KindW-1:0] kind, logic [StatusW-1:0] st,
                                    logic match, logic [7:0] ulen);
      result_t r;
      r = '0;
      r.result_kind = kind;
      r.status = st;
      r.function_code = ctrl_byte[3:0];
      r.access_demand = ctrl_byte[5];
      r.flow_control = ctrl_byte[4];
      r.direction_bit = ctrl_byte[7];
      r.primary_bit = ctrl_byte[6];
      r.address_match = match;
      r.user_length = ulen;
      return r;
    endfunction

    function void note_rx_item(logic op, logic [7:0] b);
      result_t r;
      bit has;
      bit match;
      bit fixed;
      int unsigned n;
      int unsigned fl;
      logic [StatusW-1:0] st;
      r = '0;
      has = 0;
      n = octets();
      fixed = fsm inside {S_FIX_BODY, S_FIX_SUM, S_FIX_END_GOOD, S_FIX_END_BADSUM};
      if (op == OP_TIMEOUT) begin
        // a partial frame is closed out; control bits are whatever is held
        if (fsm != S_HUNT) begin
          r = frame_summary(fixed ? KIND_FIXED : KIND_VARIABLE, ST_TIMEOUT, 1'b0, '0);
          has = 1;
        end
        fsm = S_HUNT;
      end else begin
        match = (link_addr == station);
        case (fsm)
          S_VAR_LEN: begin
            len_field = b;
            fsm = S_VAR_LEN_COPY;
          end
          S_VAR_LEN_COPY: fsm = (b == len_field) ? S_VAR_START2 : S_HUNT;
          S_VAR_START2: begin
            if (b != CHR_VARIABLE || len_field < 1 + n) begin
              fsm = S_HUNT;
            end else begin
              clear_body();
              fsm = S_VAR_BODY;
            end
          end
          S_VAR_BODY: begin
            if (absorb_body(b)) begin
              r.result_kind = KIND_DATA;
              r.data_byte = b;
              has = 1;
            end
            pos++;
            if (pos >= len_field) fsm = S_VAR_SUM;
          end
          S_FIX_BODY: begin
            void'(absorb_body(b));
            pos++;
            if (pos >= 1 + n) fsm = S_FIX_SUM;
          end
          S_VAR_SUM: fsm = (b == csum) ? S_VAR_END_GOOD : S_VAR_END_BADSUM;
          S_FIX_SUM: fsm = (b == csum) ? S_FIX_END_GOOD : S_FIX_END_BADSUM;
          S_VAR_END_GOOD, S_VAR_END_BADSUM, S_FIX_END_GOOD, S_FIX_END_BADSUM: begin
            // missing end character outranks a bad checksum
            if (b != CHR_END) st = ST_NO_END;
            else if (fsm inside {S_VAR_END_BADSUM, S_FIX_END_BADSUM}) st = ST_CHECKSUM;
            else st = ST_GOOD;
            fl = len_field;
            if (fixed) r = frame_summary(KIND_FIXED, st, match, '0);
            else r = frame_summary(KIND_VARIABLE, st, match,
                                   (fl > 1 + n) ? 8'(fl - 1 - n) : 8'd0);
            has = 1;
            fsm = S_HUNT;
          end
          default: begin
            fsm = S_HUNT;
            if (b == CHR_ACK) begin
              r.result_kind = KIND_ACK;
              r.function_code = (req_func == FUNC_REQ_CLASS1 || req_func == FUNC_REQ_CLASS2)
                                ? FUNC_ACK_NACK : FUNC_NONE;
              has = 1;
            end else if (b == CHR_FIXED) begin
              clear_body();
              fsm = S_FIX_BODY;
            end else if (b == CHR_VARIABLE) begin
              fsm = S_VAR_LEN;
            end
          end
        endcase
      end
      if (has) due.push_back(r);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        flag("unexpected item, result_kind", '0, got.result_kind);
        return;
      end
      want = due.pop_front();
      if (got.result_kind !== want.result_kind)
        flag("result_kind", want.result_kind, got.result_kind);
      if (got.data_byte !== want.data_byte) flag("data_byte", want.data_byte, got.data_byte);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.function_code !== want.function_code)
        flag("function_code", want.function_code, got.function_code);
      if (got.access_demand !== want.access_demand)
        flag("access_demand", want.access_demand, got.access_demand);
      if (got.flow_control !== want.flow_control)
        flag("flow_control", want.flow_control, got.flow_control);
      if (got.direction_bit !== want.direction_bit)
        flag("direction_bit", want.direction_bit, got.direction_bit);
      if (got.primary_bit !== want.primary_bit)
        flag("primary_bit", want.primary_bit, got.primary_bit);
      if (got.address_match !== want.address_match)
        flag("address_match", want.address_match, got.address_match);
      if (got.user_length !== want.user_length)
        flag("user_length", want.user_length, got.user_length);
    endfunction

    function void account_leftovers();
      if (due.size() != 0) begin
        mismatches += due.size();
        $display("%0d expected items never arrived", due.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic operation = OP_BYTE;
  logic [ByteW-1:0] byte_value = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [KindW-1:0] result_kind_o;
  logic [ByteW-1:0] data_byte_o;
  logic [StatusW-1:0] status_o;
  logic [FuncW-1:0] function_code_o;
  logic access_demand_o;
  logic flow_control_o;
  logic direction_bit_o;
  logic primary_bit_o;
  logic address_match_o;
  logic [ByteW-1:0] user_length_o;

  frame_scoreboard sb;
  bit quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;

  ft12_frame_receiver_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation),
    .byte_value_i    (byte_value),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind_o),
    .data_byte_o     (data_byte_o),
    .status_o        (status_o),
    .function_code_o (function_code_o),
    .access_demand_o (access_demand_o),
    .flow_control_o  (flow_control_o),
    .direction_bit_o (direction_bit_o),
    .primary_bit_o   (primary_bit_o),
    .address_match_o (address_match_o),
    .user_length_o   (user_length_o)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      sb.check_result(result_t'({result_kind_o, data_byte_o, status_o, function_code_o,
                                 access_demand_o, flow_control_o, direction_bit_o,
                                 primary_bit_o, address_match_o, user_length_o}));
      stall_left = quiet ? 0 : $urandom_range(0, 10);
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [7:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    byte_value = value;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_rx_item(op, value);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(index, value);
  endtask

  // bytes with no result may still be in flight, so keep waiting after the queue empties
  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_frame(input bit is_var, input logic [7:0] ctrl,
                            input logic [15:0] address, input int unsigned ulen,
                            input frame_fault_e fault);
    logic [7:0] body[$];
    logic [7:0] seq[$];
    logic [7:0] sum;
    logic [7:0] lval;
    int unsigned n;
    int unsigned cut;
    n = sb.octets();
    body.push_back(ctrl);
    body.push_back(address[7:0]);
    if (n == 2) body.push_back(address[15:8]);
    if (is_var) repeat (ulen) body.push_back(8'($urandom));
    sum = '0;
    foreach (body[i]) sum += body[i];
    if (is_var) begin
      lval = 8'(body.size());
      if (fault == FLT_SHORT_LEN) lval = 8'($urandom_range(0, n));
      seq.push_back(CHR_VARIABLE);
      seq.push_back(lval);
      seq.push_back((fault == FLT_LEN_DIFF) ? lval ^ 8'($urandom_range(1, 255)) : lval);
      seq.push_back((fault == FLT_NO_START2) ? CHR_VARIABLE ^ 8'($urandom_range(1, 255))
                                             : CHR_VARIABLE);
    end else begin
      seq.push_back(CHR_FIXED);
    end
    seq = {seq, body};
    seq.push_back((fault == FLT_SUM || fault == FLT_BOTH) ? sum ^ 8'($urandom_range(1, 255))
                                                          : sum);
    seq.push_back((fault == FLT_END || fault == FLT_BOTH) ? CHR_END ^ 8'($urandom_range(1, 255))
                                                          : CHR_END);
    if (fault == FLT_CUT) begin
      cut = $urandom_range(1, seq.size() - 1);
      seq = seq[0:cut-1];
    end
    foreach (seq[i]) send_item(OP_BYTE, seq[i]);
    if (fault == FLT_CUT) send_item(OP_TIMEOUT, 8'($urandom));
  endtask

  task automatic random_traffic();
    int unsigned pick;
    int unsigned ulen;
    logic [7:0] ctrl;
    logic [15:0] address;
    pick = $urandom_range(0, 99);
    ctrl = 8'($urandom);
    address = $urandom_range(0, 1) ? sb.station : 16'($urandom);
    ulen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (pick < 30) send_frame(1'b1, ctrl, address, ulen, FLT_NONE);
    else if (pick < 48) send_frame(1'b0, ctrl, address, 0, FLT_NONE);
    else if (pick < 55) send_item(OP_BYTE, CHR_ACK);
    else if (pick < 66)
      send_frame($urandom_range(0, 1), ctrl, address, ulen,
                 frame_fault_e'($urandom_range(FLT_SUM, FLT_BOTH)));
    else if (pick < 74) send_frame($urandom_range(0, 1), ctrl, address, ulen, FLT_CUT);
    else if (pick < 84)
      send_frame(1'b1, ctrl, address, ulen,
                 frame_fault_e'($urandom_range(FLT_LEN_DIFF, FLT_SHORT_LEN)));
    else if (pick < 94) send_item(OP_BYTE, 8'($urandom));
    else send_item(OP_TIMEOUT, 8'($urandom));
  endtask

  initial begin
    int unsigned budget;
    bit paused;
    logic [15:0] station;
    logic [3:0] req;
    paused = 0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    write_cfg(CFG_ADDRESS_SIZE, 16'd1);
    write_cfg(CFG_STATION_ADDRESS, 16'h00A5);
    write_cfg(CFG_REQUEST_FUNCTION, 16'(FUNC_REQ_CLASS1));
    send_item(OP_BYTE, CHR_ACK);
    send_frame(1'b0, 8'hFF, 16'h00A5, 0, FLT_NONE);
    send_item(OP_TIMEOUT, 8'hFF);
    send_frame(1'b1, 8'h00, 16'h0000, 1, FLT_NONE);
    send_frame(1'b0, 8'h5A, 16'h00A5, 0, FLT_BOTH);
    // length octets disagree: dropped silently
    send_item(OP_BYTE, CHR_VARIABLE);
    send_item(OP_BYTE, 8'h05);
    send_item(OP_BYTE, 8'h04);
    // timeout right after a start character
    send_item(OP_BYTE, CHR_VARIABLE);
    send_item(OP_TIMEOUT, 8'h00);
    // header accepted with one-octet address, then widened: user length saturates
    send_item(OP_BYTE, CHR_VARIABLE);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, CHR_VARIABLE);
    wait_drain();
    write_cfg(CFG_ADDRESS_SIZE, 16'd2);
    send_item(OP_BYTE, 8'h81);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, 8'h26);
    send_item(OP_BYTE, CHR_END);

    for (int p = 0; p < 5; p++) begin
      wait_drain();
      case (p)
        0: begin station = 16'h0000; req = 4'h0; end
        1: begin station = 16'($urandom_range(0, 255)); req = 4'hF; end
        2: begin station = 16'hFFFF; req = FUNC_REQ_CLASS1; end
        3: begin station = 16'($urandom); req = FUNC_REQ_CLASS2; end
        default: begin station = 16'h00FF; req = 4'($urandom); end
      endcase
      write_cfg(CFG_ADDRESS_SIZE, 16'(p % 4));
      write_cfg(CFG_STATION_ADDRESS, station);
      write_cfg(CFG_REQUEST_FUNCTION, 16'(req));
      quiet = (p == 2);
      budget = items_sent + 35;
      // one frame of the largest length
      if (p == 4) send_frame(1'b1, 8'($urandom), sb.station, 254 - sb.octets(), FLT_NONE);
      while (items_sent < budget) begin
        if (p == 1 && !paused && items_sent + 15 >= budget) begin
          wait_drain();
          paused = 1;
        end
        random_traffic();
      end
    end

    quiet = 1'b0;
    wait_drain();
    repeat (10) @(negedge clk);
    sb.account_leftovers();
    if (sb.mismatches == 0) begin
      $display("ft12_frame_receiver_top regression: pass");
    end else begin
      $display("ft12_frame_receiver_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ft12_frame_receiver_top regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/ft12_pkg.sv
hw/rtl/ft12_decoder.sv
hw/rtl/ft12_out_reg.sv
hw/rtl/ft12_frame_receiver_top.sv
tb/sv/tb_top.sv
